// ----- hdl/svm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sample voice mixer package
// Shared sizes, item codes and the control type of the multiply-accumulate.
// ----------------------------------------------------------------------------
package svm_pkg;

   // Number of voice slots and sample memory words (a power of two).
   localparam int NUM_VOICES   = 8;
   localparam int SAMPLE_WORDS = 16384;

   localparam int ADDR_W  = $clog2(SAMPLE_WORDS);
   localparam int VIDX_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   // Field widths of the channels.
   localparam int MODE_W  = 2;
   localparam int FADDR_W = 14;
   localparam int SMP_W   = 16;
   localparam int LEN_W   = 15;
   localparam int DLY_W   = 12;
   localparam int GAIN_W  = 16;

   // Datapath widths: gain product, full product, one contribution, sum.
   localparam int GPROD_W = 2 * GAIN_W;
   localparam int PROD_W  = SMP_W + GPROD_W + 1;
   localparam int FRAC_SH = 28;
   localparam int CONT_W  = PROD_W - FRAC_SH;
   localparam int ACC_W   = CONT_W + $clog2(NUM_VOICES + 1) + 1;

   localparam int SMP_MAX = 32767;
   localparam int SMP_MIN = -32768;

   localparam logic [GAIN_W-1:0] MASTER_RESET = 16'd16384;

   // Item codes.
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FRAME = 2'd2;

   typedef struct packed {
      logic load;   // start a frame: accumulator takes the base sample
      logic step;   // a voice sample and its gain are presented
   } svm_mac_ctl_type;

endpackage
`default_nettype wire

// ----- hdl/svm_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sample voice mixer channels
// Request, response and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface svm_req_if import svm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [FADDR_W-1:0]       address;
   logic signed [SMP_W-1:0]  sample_word;
   logic [LEN_W-1:0]         voice_length;
   logic [DLY_W-1:0]         delay_frames;
   logic [GAIN_W-1:0]        voice_gain;
   logic signed [SMP_W-1:0]  base_sample;

   modport source (output valid, mode, address, sample_word, voice_length,
                   delay_frames, voice_gain, base_sample, input ready);
   modport sink   (input valid, mode, address, sample_word, voice_length,
                   delay_frames, voice_gain, base_sample, output ready);
endinterface

interface svm_rsp_if import svm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [SMP_W-1:0]  mixed_sample;
   logic                     clipped;

   modport source (output valid, mixed_sample, clipped, input ready);
   modport sink   (input valid, mixed_sample, clipped, output ready);
endinterface

interface svm_csr_if import svm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [GAIN_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/sample_voice_mixer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sample voice mixer
// Multi-voice sample playback mixer with a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A load item writes one word of sample memory and a play item starts a voice
// in the next round-robin slot. A frame item walks the voice slots one per
// cycle: it is accepted, each slot is scanned, the multiply-accumulate
// pipeline drains and the sum is saturated into the output register. The scan
// is paced by the single shared multiplier chain in svm_mac, which takes one
// voice per cycle. The input is not ready while a frame is in progress. The
// output register holds a finished frame until it is taken, and load or play
// items are accepted meanwhile; a new frame waits in its last step until the
// output register is free. The master volume register may be written at any
// time the block is idle and is always ready.
// Sample memory is not cleared at reset: read only words that were loaded.
// ----------------------------------------------------------------------------
module sample_voice_mixer import svm_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   svm_req_if.sink     req_ch,
   svm_rsp_if.source   rsp_ch,
   svm_csr_if.sink     csr_ch
);

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

   logic [1:0]               state_ff;
   logic [1:0]               state_in;
   logic [VIDX_W-1:0]        vidx_ff;
   logic [VIDX_W-1:0]        vidx_in;
   logic [1:0]               drain_ff;
   logic [1:0]               drain_in;
   logic [VIDX_W-1:0]        next_slot_ff;
   logic [GAIN_W-1:0]        master_ff;

   // Voice slots. Only the active bits need a reset value.
   logic                     slot_act_ff   [NUM_VOICES];
   logic [FADDR_W-1:0]       slot_start_ff [NUM_VOICES];
   logic [LEN_W-1:0]         slot_len_ff   [NUM_VOICES];
   logic [LEN_W-1:0]         slot_pos_ff   [NUM_VOICES];
   logic [DLY_W-1:0]         slot_dly_ff   [NUM_VOICES];
   logic [GAIN_W-1:0]        slot_gain_ff  [NUM_VOICES];

   logic [SMP_W-1:0]         mem [SAMPLE_WORDS];
   logic signed [SMP_W-1:0]  rd_ff;
   logic [GAIN_W-1:0]        gain_ff;
   logic                     iss_ff;

   logic                     rsp_vld_ff;
   logic signed [SMP_W-1:0]  rsp_smp_ff;
   logic signed [SMP_W-1:0]  rsp_smp_in;
   logic                     rsp_clip_ff;
   logic                     rsp_clip_in;

   logic                     acc_any;
   logic                     acc_load;
   logic                     acc_play;
   logic                     acc_frame;
   logic                     in_scan;
   logic                     cur_act;
   logic [DLY_W-1:0]         cur_dly;
   logic [LEN_W-1:0]         cur_pos;
   logic [LEN_W-1:0]         pos_inc;
   logic                     issue;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     rsp_free;
   logic                     out_fire;
   svm_mac_ctl_type          mac_ctl;
   logic signed [ACC_W-1:0]  acc;

   // Input handshake and item decoding.
   assign req_ch.ready = (state_ff == S_IDLE);
   assign acc_any      = req_ch.valid && req_ch.ready;
   assign acc_load     = acc_any && (req_ch.mode == MODE_LOAD);
   assign acc_play     = acc_any && (req_ch.mode == MODE_PLAY);
   assign acc_frame    = acc_any && (req_ch.mode == MODE_FRAME);

   // The register port never stalls.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= MASTER_RESET;
      end else if (csr_ch.valid) begin
         master_ff <= csr_ch.data;
      end
   end

   // The slot under the scan pointer. A voice with a pending delay only counts
   // its delay down; a voice with no delay left issues one sample read.
   assign in_scan = (state_ff == S_SCAN);
   assign cur_act = slot_act_ff[vidx_ff];
   assign cur_dly = slot_dly_ff[vidx_ff];
   assign cur_pos = slot_pos_ff[vidx_ff];
   assign pos_inc = cur_pos + LEN_W'(1);
   assign issue   = in_scan && cur_act && (cur_dly == '0);
   // Addresses wrap around the end of the sample memory.
   assign rd_addr = ADDR_W'(slot_start_ff[vidx_ff]) + ADDR_W'(cur_pos);

   // Sequencer.
   assign rsp_free = !rsp_vld_ff || rsp_ch.ready;
   assign out_fire = (state_ff == S_OUT) && rsp_free;

   always_comb begin
      state_in = state_ff;
      vidx_in  = vidx_ff;
      drain_in = drain_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc_frame) begin
               state_in = S_SCAN;
               vidx_in  = '0;
            end
         end
         S_SCAN: begin
            vidx_in = vidx_ff + VIDX_W'(1);
            if (vidx_ff == LAST_VOICE) begin
               state_in = S_DRAIN;
               drain_in = '0;
            end
         end
         S_DRAIN: begin
            // Wait until the last contribution has passed the read register and the mac pipeline into the sum.
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd2) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vidx_ff      <= '0;
         drain_ff     <= '0;
         next_slot_ff <= '0;
         iss_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         vidx_ff  <= vidx_in;
         drain_ff <= drain_in;
         iss_ff   <= issue;
         if (acc_play) begin
            next_slot_ff <= (next_slot_ff == LAST_VOICE) ? '0
                                                          : next_slot_ff + VIDX_W'(1);
         end
      end
   end

   // Active bits: a play sets or clears its slot, the scan frees a voice after
   // its last sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VOICES; i++) begin
            slot_act_ff[i] <= 1'b0;
         end
      end else if (acc_play) begin
         slot_act_ff[next_slot_ff] <= (req_ch.voice_length != '0);
      end else if (issue && (pos_inc >= slot_len_ff[vidx_ff])) begin
         slot_act_ff[vidx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_play) begin
         slot_start_ff[next_slot_ff] <= req_ch.address;
         slot_len_ff[next_slot_ff]   <= req_ch.voice_length;
         slot_pos_ff[next_slot_ff]   <= '0;
         slot_dly_ff[next_slot_ff]   <= req_ch.delay_frames;
         slot_gain_ff[next_slot_ff]  <= req_ch.voice_gain;
      end else if (in_scan && cur_act) begin
         if (cur_dly != '0) begin
            slot_dly_ff[vidx_ff] <= cur_dly - DLY_W'(1);
         end else begin
            slot_pos_ff[vidx_ff] <= pos_inc;
         end
      end
   end

   // Sample memory: written by load items, read once per sounding voice.
   always_ff @(posedge clock) begin
      if (acc_load) begin
         mem[ADDR_W'(req_ch.address)] <= req_ch.sample_word;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ff   <= signed'(mem[rd_addr]);
         gain_ff <= slot_gain_ff[vidx_ff];
      end
   end

   assign mac_ctl.load = acc_frame;
   assign mac_ctl.step = iss_ff;

   svm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .sample (rd_ff),
      .gain   (gain_ff),
      .master (master_ff),
      .base   (req_ch.base_sample),
      .acc    (acc)
   );

   // Only the final sum is saturated, and the flag records that it was.
   always_comb begin
      rsp_smp_in  = SMP_W'(acc);
      rsp_clip_in = 1'b0;
      if (acc > SMP_MAX) begin
         rsp_smp_in  = SMP_W'(SMP_MAX);
         rsp_clip_in = 1'b1;
      end else if (acc < SMP_MIN) begin
         rsp_smp_in  = SMP_W'(SMP_MIN);
         rsp_clip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_fire) begin
         rsp_smp_ff  <= rsp_smp_in;
         rsp_clip_ff <= rsp_clip_in;
      end
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.mixed_sample = rsp_smp_ff;
   assign rsp_ch.clipped      = rsp_clip_ff;

`ifndef NO_ASSERTIONS
   // A result appears only as the last step of a frame.
   a_rsp_from_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside the output step of a frame");

   // Sample reads are issued only while the slots are scanned.
   a_issue_in_scan: assert property (@(posedge clock) disable iff (reset)
      iss_ff |-> $past(state_ff == S_SCAN))
      else $error("voice sample issued outside the slot scan");

   // The accumulator pipeline is empty whenever a new item can be taken.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !iss_ff)
      else $error("multiply-accumulate still busy while idle");

   // The round-robin slot pointer moves only on a play item.
   a_slot_on_play: assert property (@(posedge clock) disable iff (reset)
      !$stable(next_slot_ff) |-> $past(acc_play))
      else $error("slot pointer moved without a play item");
`endif

endmodule
`default_nettype wire

// ----- hdl/svm_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sample voice mixer multiply-accumulate
// Three-stage shared unit: gain product, sample product, rounded accumulate.
// ----------------------------------------------------------------------------
module svm_mac import svm_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire svm_mac_ctl_type          ctl,
   input  wire logic signed [SMP_W-1:0]  sample,
   input  wire logic [GAIN_W-1:0]        gain,
   input  wire logic [GAIN_W-1:0]        master,
   input  wire logic signed [SMP_W-1:0]  base,
   output logic signed [ACC_W-1:0]       acc
);

   logic                      a_vld_ff;
   logic signed [SMP_W-1:0]   smp_ff;
   logic [GPROD_W-1:0]        g_ff;
   logic [GPROD_W-1:0]        g_in;
   logic                      b_vld_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  rnd;
   logic signed [CONT_W-1:0]  contrib;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;

   assign g_in    = GPROD_W'(gain) * GPROD_W'(master);
   assign prod_in = PROD_W'(smp_ff) * PROD_W'(signed'({1'b0, g_ff}));
   // Round half up, then drop the fraction bits with an arithmetic shift.
   assign rnd     = prod_ff + (PROD_W'(1) <<< (FRAC_SH - 1));
   assign contrib = CONT_W'(rnd >>> FRAC_SH);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = ACC_W'(base);
      end else if (b_vld_ff) begin
         acc_in = acc_ff + ACC_W'(contrib);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= ctl.step;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff  <= sample;
      g_ff    <= g_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire
